// ===== sv/charged_lru_cache_with_pinning_core_assert.svh =====
// ----------------------------------------------------------------------------
// Charged LRU cache assertion macros
// Shorthand for clocked, reset-gated checks in the cache core.
// ----------------------------------------------------------------------------
`ifndef CHARGED_LRU_CACHE_WITH_PINNING_CORE_ASSERT_SVH
`define CHARGED_LRU_CACHE_WITH_PINNING_CORE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define CLC_ASSERT_IMPLY(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("cache core check failed");

// Check that a condition implies a consequence in the next cycle
`define CLC_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("cache core sequence check failed");

`endif

// ===== sv/clc_pkg.sv =====
// ----------------------------------------------------------------------------
// Charged LRU cache package
// Sizes, operation and status codes, and sequencer states of the cache core.
// ----------------------------------------------------------------------------
package clc_pkg;

    localparam int ENTRIES  = 32;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int PTR_W    = $clog2(ENTRIES + 1);
    localparam int CNT_W    = PTR_W;

    localparam logic [PTR_W-1:0] NIL      = PTR_W'(ENTRIES);
    localparam logic [63:0]      KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);
    localparam logic [15:0]      REFS_MAX = 16'hFFFF;

    // Operation codes
    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_LOOKUP  = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_ERASE   = 3'd3;
    localparam logic [2:0] OP_TRIM    = 3'd4;
    localparam logic [2:0] OP_PURGE   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;

    // Result kinds
    localparam logic KIND_ANSWER = 1'b0;
    localparam logic KIND_FREED  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_STRICT   = 1'b1;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_EVICT  = 12'b0000_0000_0010,
        S_STRICT = 12'b0000_0000_0100,
        S_FSCAN  = 12'b0000_0000_1000,
        S_KSCAN  = 12'b0000_0001_0000,
        S_KOLD   = 12'b0000_0010_0000,
        S_KNEW   = 12'b0000_0100_0000,
        S_LOOK   = 12'b0000_1000_0000,
        S_REL    = 12'b0001_0000_0000,
        S_ERASE  = 12'b0010_0000_0000,
        S_OLOAD  = 12'b0100_0000_0000,
        S_OSEND  = 12'b1000_0000_0000
    } state_t;

endpackage

// ===== sv/charged_lru_cache_with_pinning_core.sv =====
// ----------------------------------------------------------------------------
// Charged LRU cache with pinning
// Fixed-slot key-value cache with charges, reference counts and an LRU list.
// ----------------------------------------------------------------------------
// One request is taken at a time; s_tready is low until its last result beat
// leaves, and the core goes back to its idle state before it takes the next one.
// The slot table has a single read port driven by a small sequencer, so a
// request steps through: one eviction step per evicted entry plus one to end
// the walk, the strict check of an insert, the free-slot and key scans (each
// up to 32 slots, one slot per step), at most two update steps, and a load and
// a send step per result beat. Freed entries are emitted first (kind 1), then
// the answer (kind 0, tlast high); every beat carries the totals after the
// whole request.
module charged_lru_cache_with_pinning_core
    import clc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // key[63:0], key_hash[95:64], value[159:96], charge[191:160],
    // want_handle[192], handle_index[197:193], zero fill [199:198]
    input  logic [199:0] s_tdata,
    // operation[2:0]
    input  logic [2:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], hit[2], handle_out[7:3], value_out[71:8], key_out[135:72],
    // usage[175:136], pinned_usage[215:176]
    output logic [215:0] m_tdata,
    // entry_kind[0]
    output logic         m_tuser,
    output logic         m_tlast,
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [39:0]  cfg_data
);

    // Slot table and freed-slot queue
    logic [63:0]      slot_key_mem    [ENTRIES];
    logic [31:0]      slot_hash_mem   [ENTRIES];
    logic [63:0]      slot_value_mem  [ENTRIES];
    logic [31:0]      slot_charge_mem [ENTRIES];
    logic [PTR_W-1:0] lru_prev_mem    [ENTRIES];
    logic [PTR_W-1:0] lru_next_mem    [ENTRIES];
    logic [IDX_W-1:0] fq_mem          [ENTRIES];
    logic [15:0]      slot_refs_reg   [ENTRIES];
    logic [ENTRIES-1:0] slot_in_cache_reg;

    // Control state
    state_t           state_reg;
    logic [PTR_W-1:0] lru_oldest_reg, lru_newest_reg;
    logic [39:0]      usage_reg, lru_charge_reg;
    logic [39:0]      capacity_reg;
    logic             strict_reg;
    logic [CNT_W-1:0] scan_reg, fq_cnt_reg, rd_ptr_reg;
    logic [IDX_W-1:0] found_reg, free_reg;
    logic             found_v_reg, commit_reg;

    // Latched request
    logic [2:0]       op_reg;
    logic [63:0]      key_reg, val_reg;
    logic [31:0]      hash_reg, chg_reg;
    logic             want_reg;
    logic [IDX_W-1:0] hidx_reg;
    logic [4:0]       hidx_raw_reg;

    // Answer and output beat
    logic [1:0]       fin_status_reg;
    logic             fin_hit_reg;
    logic [IDX_W-1:0] fin_handle_reg;
    logic [63:0]      fin_value_reg, fin_key_reg;
    logic             o_kind_reg, o_hit_reg, o_last_reg;
    logic [1:0]       o_status_reg;
    logic [4:0]       o_handle_reg;
    logic [63:0]      o_value_reg, o_key_reg;

    // Read port
    logic [IDX_W-1:0] rd_idx;
    logic [63:0]      rd_key, rd_value;
    logic [31:0]      rd_hash, rd_charge;
    logic [PTR_W-1:0] rd_prev, rd_next;
    logic [15:0]      rd_refs;
    logic             rd_inc;

    // Actions of the cycle
    logic             evicting, over_cap, rel_ok, hit_ok, key_match, strict_fail;
    logic             do_unlink, do_push, do_free;
    logic [IDX_W-1:0] push_idx;
    logic [31:0]      push_charge;
    logic [40:0]      evict_sum, strict_sum;
    logic             s_acc, m_acc;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid & s_tready;
    assign m_acc     = m_tvalid & m_tready;

    // Select the table address for the current step
    always_comb
    begin
        case (state_reg)
            S_EVICT:              rd_idx = lru_oldest_reg[IDX_W-1:0];
            S_FSCAN, S_KSCAN:     rd_idx = scan_reg[IDX_W-1:0];
            S_KOLD, S_LOOK, S_ERASE: rd_idx = found_reg;
            S_REL:                rd_idx = hidx_reg;
            S_OLOAD:              rd_idx = fq_mem[rd_ptr_reg[IDX_W-1:0]];
            default:              rd_idx = free_reg;
        endcase
    end

    assign rd_key    = slot_key_mem[rd_idx];
    assign rd_hash   = slot_hash_mem[rd_idx];
    assign rd_value  = slot_value_mem[rd_idx];
    assign rd_charge = slot_charge_mem[rd_idx];
    assign rd_prev   = lru_prev_mem[rd_idx];
    assign rd_next   = lru_next_mem[rd_idx];
    assign rd_refs   = slot_refs_reg[rd_idx];
    assign rd_inc    = slot_in_cache_reg[rd_idx];

    // Decide the list and slot actions of this step
    always_comb
    begin
        evict_sum   = {1'b0, usage_reg} +
                      ((op_reg == OP_INSERT) ? {9'd0, chg_reg} : 41'd0);
        strict_sum  = {1'b0, usage_reg - lru_charge_reg} + {9'd0, chg_reg};
        strict_fail = strict_reg && (strict_sum > {1'b0, capacity_reg});
        over_cap    = usage_reg > capacity_reg;
        evicting    = (state_reg == S_EVICT) && (lru_oldest_reg != NIL) &&
                      ((op_reg == OP_PURGE) || (evict_sum > {1'b0, capacity_reg}));
        key_match   = rd_inc && (rd_key == key_reg) && (rd_hash == hash_reg);
        hit_ok      = found_v_reg && (rd_refs != REFS_MAX);
        rel_ok      = ({1'b0, hidx_raw_reg} < PTR_W'(ENTRIES)) && (rd_refs != 16'd0) &&
                      !(rd_inc && (rd_refs == 16'd1));

        do_unlink = evicting ||
                    ((state_reg == S_KOLD) && (rd_refs == 16'd1)) ||
                    ((state_reg == S_LOOK) && hit_ok && (rd_refs == 16'd1)) ||
                    ((state_reg == S_ERASE) && found_v_reg && (rd_refs == 16'd1));
        do_free   = evicting ||
                    ((state_reg == S_KOLD) && (rd_refs == 16'd1)) ||
                    ((state_reg == S_ERASE) && found_v_reg && (rd_refs == 16'd1)) ||
                    ((state_reg == S_REL) && rel_ok &&
                     ((rd_refs == 16'd1) || ((rd_refs == 16'd2) && rd_inc && over_cap)));
        do_push   = ((state_reg == S_KNEW) && !want_reg) ||
                    ((state_reg == S_REL) && rel_ok && (rd_refs == 16'd2) &&
                     rd_inc && !over_cap);
        push_idx    = (state_reg == S_KNEW) ? free_reg : hidx_reg;
        push_charge = (state_reg == S_KNEW) ? chg_reg : rd_charge;
    end

    // Update table payload, links and the freed queue
    always_ff @(posedge clk)
    begin
        if (do_unlink)
        begin
            if (rd_prev != NIL)
                lru_next_mem[rd_prev[IDX_W-1:0]] <= rd_next;
            if (rd_next != NIL)
                lru_prev_mem[rd_next[IDX_W-1:0]] <= rd_prev;
        end
        if (do_push)
        begin
            lru_prev_mem[push_idx] <= lru_newest_reg;
            lru_next_mem[push_idx] <= NIL;
            if (lru_newest_reg != NIL)
                lru_next_mem[lru_newest_reg[IDX_W-1:0]] <= {1'b0, push_idx};
        end
        if (do_free)
            fq_mem[fq_cnt_reg[IDX_W-1:0]] <= rd_idx;
        // Commit the inserted entry once its slot's old contents went out
        if ((state_reg == S_OLOAD) && (rd_ptr_reg == fq_cnt_reg) && commit_reg)
        begin
            slot_key_mem[free_reg]    <= key_reg;
            slot_hash_mem[free_reg]   <= hash_reg;
            slot_value_mem[free_reg]  <= val_reg;
            slot_charge_mem[free_reg] <= chg_reg;
        end
    end

    // Sequencer, counts and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            lru_oldest_reg    <= NIL;
            lru_newest_reg    <= NIL;
            usage_reg         <= '0;
            lru_charge_reg    <= '0;
            capacity_reg      <= '0;
            strict_reg        <= 1'b0;
            scan_reg          <= '0;
            fq_cnt_reg        <= '0;
            rd_ptr_reg        <= '0;
            found_v_reg       <= 1'b0;
            commit_reg        <= 1'b0;
            slot_in_cache_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
                slot_refs_reg[i] <= '0;
        end
        else
        begin
            // Take configuration writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CAPACITY)
                    capacity_reg <= cfg_data;
                else
                    strict_reg <= cfg_data[0];
            end

            // Apply list moves
            if (do_unlink)
            begin
                if (rd_prev == NIL)
                    lru_oldest_reg <= rd_next;
                if (rd_next == NIL)
                    lru_newest_reg <= rd_prev;
                lru_charge_reg <= lru_charge_reg - 40'(rd_charge);
            end
            if (do_push)
            begin
                if (lru_newest_reg == NIL)
                    lru_oldest_reg <= {1'b0, push_idx};
                lru_newest_reg <= {1'b0, push_idx};
                lru_charge_reg <= lru_charge_reg + 40'(push_charge);
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_acc)
                    begin
                        found_v_reg <= 1'b0;
                        commit_reg  <= 1'b0;
                        scan_reg    <= '0;
                        rd_ptr_reg  <= '0;
                        fq_cnt_reg  <= '0;
                        case (s_tuser)
                            OP_INSERT, OP_TRIM, OP_PURGE: state_reg <= S_EVICT;
                            OP_LOOKUP, OP_ERASE:          state_reg <= S_KSCAN;
                            OP_RELEASE:                   state_reg <= S_REL;
                            default:                      state_reg <= S_OLOAD;
                        endcase
                    end
                end
                S_EVICT:
                begin
                    if (!evicting)
                        state_reg <= (op_reg == OP_INSERT) ? S_STRICT : S_OLOAD;
                end
                S_STRICT:
                begin
                    state_reg <= strict_fail ? S_OLOAD : S_FSCAN;
                end
                S_FSCAN:
                begin
                    if (rd_refs == 16'd0)
                    begin
                        scan_reg  <= '0;
                        state_reg <= S_KSCAN;
                    end
                    else if (scan_reg == CNT_W'(ENTRIES - 1))
                        state_reg <= S_OLOAD;
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_KSCAN:
                begin
                    if (key_match || (scan_reg == CNT_W'(ENTRIES - 1)))
                    begin
                        found_v_reg <= key_match;
                        case (op_reg)
                            OP_INSERT: state_reg <= key_match ? S_KOLD : S_KNEW;
                            OP_LOOKUP: state_reg <= S_LOOK;
                            default:   state_reg <= S_ERASE;
                        endcase
                    end
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_KOLD:
                begin
                    if (!do_free)
                    begin
                        slot_in_cache_reg[rd_idx] <= 1'b0;
                        slot_refs_reg[rd_idx]     <= rd_refs - 16'd1;
                    end
                    state_reg <= S_KNEW;
                end
                S_KNEW:
                begin
                    slot_in_cache_reg[free_reg] <= 1'b1;
                    slot_refs_reg[free_reg]     <= want_reg ? 16'd2 : 16'd1;
                    usage_reg                   <= usage_reg + 40'(chg_reg);
                    commit_reg                  <= 1'b1;
                    state_reg                   <= S_OLOAD;
                end
                S_LOOK:
                begin
                    if (hit_ok)
                        slot_refs_reg[rd_idx] <= rd_refs + 16'd1;
                    state_reg <= S_OLOAD;
                end
                S_REL:
                begin
                    if (rel_ok && !do_free)
                        slot_refs_reg[rd_idx] <= rd_refs - 16'd1;
                    state_reg <= S_OLOAD;
                end
                S_ERASE:
                begin
                    if (found_v_reg && !do_free)
                    begin
                        slot_refs_reg[rd_idx]     <= rd_refs - 16'd1;
                        slot_in_cache_reg[rd_idx] <= 1'b0;
                    end
                    state_reg <= S_OLOAD;
                end
                S_OLOAD:
                begin
                    state_reg <= S_OSEND;
                end
                S_OSEND:
                begin
                    if (m_acc)
                    begin
                        if (o_last_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            rd_ptr_reg <= rd_ptr_reg + 1'b1;
                            state_reg  <= S_OLOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Free a slot: drop its count and charge, queue it for output
            if (do_free)
            begin
                slot_refs_reg[rd_idx]     <= '0;
                slot_in_cache_reg[rd_idx] <= 1'b0;
                usage_reg                 <= usage_reg - 40'(rd_charge);
                fq_cnt_reg                <= fq_cnt_reg + 1'b1;
            end
        end
    end

    // Latch the request, build the answer and the output beat
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    op_reg         <= s_tuser;
                    key_reg        <= s_tdata[63:0] & KEY_MASK;
                    hash_reg       <= s_tdata[95:64];
                    val_reg        <= s_tdata[159:96];
                    chg_reg        <= s_tdata[191:160];
                    want_reg       <= s_tdata[192];
                    hidx_raw_reg   <= s_tdata[197:193];
                    hidx_reg       <= s_tdata[193 +: IDX_W];
                    fin_status_reg <= ST_OK;
                    fin_hit_reg    <= 1'b0;
                    fin_handle_reg <= '0;
                    fin_value_reg  <= '0;
                    fin_key_reg    <= '0;
                end
            end
            S_STRICT:
            begin
                if (strict_fail)
                begin
                    fin_status_reg <= ST_REFUSED;
                    fin_value_reg  <= val_reg;
                    fin_key_reg    <= key_reg;
                end
            end
            S_FSCAN:
            begin
                if (rd_refs == 16'd0)
                    free_reg <= scan_reg[IDX_W-1:0];
                else if (scan_reg == CNT_W'(ENTRIES - 1))
                begin
                    fin_status_reg <= ST_NO_SLOT;
                    fin_value_reg  <= val_reg;
                    fin_key_reg    <= key_reg;
                end
            end
            S_KSCAN:
            begin
                found_reg <= scan_reg[IDX_W-1:0];
            end
            S_KNEW:
            begin
                fin_hit_reg    <= want_reg;
                fin_handle_reg <= want_reg ? free_reg : '0;
            end
            S_LOOK:
            begin
                if (hit_ok)
                begin
                    fin_hit_reg    <= 1'b1;
                    fin_handle_reg <= found_reg;
                    fin_value_reg  <= rd_value;
                end
            end
            S_OLOAD:
            begin
                if (rd_ptr_reg != fq_cnt_reg)
                begin
                    o_kind_reg   <= KIND_FREED;
                    o_status_reg <= ST_OK;
                    o_hit_reg    <= 1'b0;
                    o_handle_reg <= 5'(rd_idx);
                    o_value_reg  <= rd_value;
                    o_key_reg    <= rd_key;
                    o_last_reg   <= 1'b0;
                end
                else
                begin
                    o_kind_reg   <= KIND_ANSWER;
                    o_status_reg <= fin_status_reg;
                    o_hit_reg    <= fin_hit_reg;
                    o_handle_reg <= 5'(fin_handle_reg);
                    o_value_reg  <= fin_value_reg;
                    o_key_reg    <= fin_key_reg;
                    o_last_reg   <= 1'b1;
                end
            end
            default:
            begin
                o_last_reg <= o_last_reg;
            end
        endcase
    end

    // Drive the result beat
    assign m_tvalid = (state_reg == S_OSEND);
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {usage_reg - lru_charge_reg, usage_reg, o_key_reg, o_value_reg,
                       o_handle_reg, o_hit_reg, o_status_reg};

    `include "charged_lru_cache_with_pinning_core_assert.svh"

    // No new request while a result beat is offered
    `CLC_ASSERT_IMPLY(a_busy_out, m_tvalid, !s_tready)
    // An empty oldest list end implies an empty newest end
    `CLC_ASSERT_IMPLY(a_lru_ends, lru_oldest_reg == NIL, lru_newest_reg == NIL)
    // Listed charge does not exceed total usage while idle
    `CLC_ASSERT_IMPLY(a_lru_charge, state_reg == S_IDLE, lru_charge_reg <= usage_reg)
    // After the answer is taken the core is idle and the freed queue has not overflowed
    `CLC_ASSERT_NEXT(a_answer_last, m_acc && m_tlast, s_tready && (fq_cnt_reg <= CNT_W'(ENTRIES)))

endmodule
